/* sv/sparse_matrix_multiply_assert.svh */
// Assertion macros used by the RTL in sparse_matrix_multiply.sv.
`ifndef SPARSE_MATRIX_MULTIPLY_ASSERT_SVH
`define SPARSE_MATRIX_MULTIPLY_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define SMM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define SMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/smm_pkg.sv */
package smm_pkg;

    localparam int DIM_W    = 6;
    localparam int CFG_W    = 7;
    localparam int SUM_W    = 40;
    localparam int CNT_W    = 13;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int CADDR_W  = 2;

    localparam logic [CFG_W-1:0] DIM_MAX = 7'd64;

    localparam logic [KIND_W-1:0] KIND_LOAD_A = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_B = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FETCH  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] STS_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] STS_FULL  = 3'd1;
    localparam logic [STATUS_W-1:0] STS_RANGE = 3'd2;
    localparam logic [STATUS_W-1:0] STS_ORDER = 3'd3;
    localparam logic [STATUS_W-1:0] STS_ZERO  = 3'd4;
    localparam logic [STATUS_W-1:0] STS_ENTRY = 3'd5;
    localparam logic [STATUS_W-1:0] STS_DONE  = 3'd6;

    localparam logic [CADDR_W-1:0] CFG_A_ROWS = 2'd0;
    localparam logic [CADDR_W-1:0] CFG_INNER  = 2'd1;
    localparam logic [CADDR_W-1:0] CFG_B_COLS = 2'd2;

    // Clamp a dimension write to 1..DIM_MAX.
    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] d;
        d = v;
        if (d == '0) begin
            d = 7'd1;
        end else if (d > DIM_MAX) begin
            d = DIM_MAX;
        end
        return d;
    endfunction

endpackage

/* sv/smm_ram.sv */
module smm_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/sparse_matrix_multiply.sv */
// Sparse matrix product over triplet stores.
// Input words (s_ channel) carry a kind in s_tuser: load an A term, load a B
// term, fetch the next product entry, or clear both stores. Every input word
// yields exactly one result word on the m_ channel, with a status in m_tuser.
// Loads and clear are answered by writing the result register at the edge
// that accepts the word. A fetch walks product positions in row-major order
// from a cursor; per position it sets up (S_POS), runs merge steps of a memory
// read then a compare (S_RD, S_CMP) and closes (S_RD, S_END), where the steps
// run over the A terms of that row and all stored B terms. Its pace is set by
// the one-read-per-cycle port of each term memory.
// Configuration writes (cfg_wr_en, cfg_addr, cfg_wdata) set the dimensions
// and restart the enumeration; issue them only while the block is idle.
// Reset (aresetn low, synchronous) empties both stores and restores all
// dimensions to 64. A stalled receiver holds the result word; no new input
// word is taken until that word has gone, and a finished fetch waits in place.
module sparse_matrix_multiply #(
    parameter int MAX_TERMS  = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration
    input  logic                         cfg_wr_en,
    input  logic [smm_pkg::CADDR_W-1:0]  cfg_addr,
    input  logic [smm_pkg::CFG_W-1:0]    cfg_wdata,
    // input words
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [31:0]                  s_tdata,  // term_row, term_col, term_value
    input  logic [smm_pkg::KIND_W-1:0]   s_tuser,  // kind
    // result words
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [71:0]                  m_tdata,  // row, col, value, count
    output logic [smm_pkg::STATUS_W-1:0] m_tuser   // status
);

    `include "sparse_matrix_multiply_assert.svh"

    localparam int AW = $clog2(MAX_TERMS);
    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam int DW = smm_pkg::DIM_W;
    localparam int TW = 2 * DW + VALUE_BITS;
    localparam int PW = (2 * VALUE_BITS > smm_pkg::SUM_W) ? 2 * VALUE_BITS : smm_pkg::SUM_W;
    localparam int SW = smm_pkg::SUM_W;
    localparam int NW = smm_pkg::CNT_W;
    localparam int FW = smm_pkg::CFG_W;

    typedef enum logic [2:0] {S_IDLE, S_POS, S_RD, S_CMP, S_END} state_t;

    // input word fields
    logic [DW-1:0]                 in_row, in_col;
    logic [31:0]                   in_val_ext;
    logic [VALUE_BITS-1:0]         in_val;
    logic [smm_pkg::KIND_W-1:0]    in_kind;
    logic                          in_acc;

    assign in_row     = s_tdata[DW-1:0];
    assign in_col     = s_tdata[2*DW-1:DW];
    assign in_val_ext = {16'b0, s_tdata[2*DW+15:2*DW]};
    assign in_val     = in_val_ext[VALUE_BITS-1:0];
    assign in_kind    = s_tuser;
    assign in_acc     = s_tvalid && s_tready;

    // registers
    state_t                 state_reg, state_next;
    logic [FW-1:0]          a_rows_reg, a_rows_next, inner_reg, inner_next;
    logic [FW-1:0]          b_cols_reg, b_cols_next;
    logic [CW-1:0]          a_terms_reg, a_terms_next, b_terms_reg, b_terms_next;
    logic [DW-1:0]          a_lrow_reg, a_lrow_next, a_lcol_reg, a_lcol_next;
    logic [DW-1:0]          b_lrow_reg, b_lrow_next, b_lcol_reg, b_lcol_next;
    logic [FW-1:0]          cur_row_reg, cur_row_next, cur_col_reg, cur_col_next;
    logic [CW-1:0]          base_reg, base_next, i_reg, i_next, j_reg, j_next;
    logic [SW-1:0]          acc_reg, acc_next, prod_reg, prod_next;
    logic                   pend_reg, pend_next, fin_reg, fin_next;
    logic [NW-1:0]          emit_reg, emit_next;
    logic                   m_valid_reg, m_valid_next;
    logic [smm_pkg::STATUS_W-1:0] o_sts_reg, o_sts_next;
    logic [DW-1:0]          o_row_reg, o_row_next, o_col_reg, o_col_next;
    logic [SW-1:0]          o_val_reg, o_val_next;
    logic [NW-1:0]          o_cnt_reg, o_cnt_next;

    // term memories
    logic          a_we, b_we;
    logic [TW-1:0] a_rdata, b_rdata, wr_term;

    assign wr_term = {in_val, in_col, in_row};

    smm_ram #(.WIDTH(TW), .DEPTH(MAX_TERMS)) u_a_ram (
        .aclk (aclk),
        .we   (a_we),
        .waddr(a_terms_reg[AW-1:0]),
        .wdata(wr_term),
        .raddr(i_reg[AW-1:0]),
        .rdata(a_rdata)
    );

    smm_ram #(.WIDTH(TW), .DEPTH(MAX_TERMS)) u_b_ram (
        .aclk (aclk),
        .we   (b_we),
        .waddr(b_terms_reg[AW-1:0]),
        .wdata(wr_term),
        .raddr(j_reg[AW-1:0]),
        .rdata(b_rdata)
    );

    // read-back fields
    logic [DW-1:0]                 a_row, a_col, b_row, b_col;
    logic signed [VALUE_BITS-1:0]  a_val, b_val;
    logic signed [2*VALUE_BITS-1:0] prod_n;
    logic signed [PW-1:0]          prod_x;

    assign a_row  = a_rdata[DW-1:0];
    assign a_col  = a_rdata[2*DW-1:DW];
    assign a_val  = a_rdata[TW-1:2*DW];
    assign b_row  = b_rdata[DW-1:0];
    assign b_col  = b_rdata[2*DW-1:DW];
    assign b_val  = b_rdata[TW-1:2*DW];
    assign prod_n = a_val * b_val;
    assign prod_x = PW'(prod_n);

    // load checks
    logic                          load_b, out_free;
    logic [FW-1:0]                 rlim, clim;
    logic [CW-1:0]                 lterms;
    logic [DW-1:0]                 lrow, lcol;
    logic [smm_pkg::STATUS_W-1:0]  load_sts;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign load_b   = (in_kind == smm_pkg::KIND_LOAD_B);
    assign rlim     = load_b ? inner_reg : a_rows_reg;
    assign clim     = load_b ? b_cols_reg : inner_reg;
    assign lterms   = load_b ? b_terms_reg : a_terms_reg;
    assign lrow     = load_b ? b_lrow_reg : a_lrow_reg;
    assign lcol     = load_b ? b_lcol_reg : a_lcol_reg;

    always_comb begin
        if ({1'b0, in_row} >= rlim || {1'b0, in_col} >= clim) begin
            load_sts = smm_pkg::STS_RANGE;
        end else if (in_val == '0) begin
            load_sts = smm_pkg::STS_ZERO;
        end else if (lterms != '0 && {in_row, in_col} <= {lrow, lcol}) begin
            load_sts = smm_pkg::STS_ORDER;
        end else if (lterms >= CW'(MAX_TERMS)) begin
            load_sts = smm_pkg::STS_FULL;
        end else begin
            load_sts = smm_pkg::STS_OK;
        end
    end

    assign a_we = in_acc && in_kind == smm_pkg::KIND_LOAD_A && load_sts == smm_pkg::STS_OK;
    assign b_we = in_acc && load_b && load_sts == smm_pkg::STS_OK;

    // cursor advance
    logic [FW-1:0] col_inc, adv_row, adv_col;

    always_comb begin
        col_inc = cur_col_reg + 1'b1;
        if (col_inc >= b_cols_reg) begin
            adv_col = '0;
            adv_row = cur_row_reg + 1'b1;
        end else begin
            adv_col = col_inc;
            adv_row = cur_row_reg;
        end
    end

    always_comb begin
        logic restart;
        restart      = 1'b0;
        state_next   = state_reg;
        a_rows_next  = a_rows_reg;
        inner_next   = inner_reg;
        b_cols_next  = b_cols_reg;
        a_terms_next = a_terms_reg;
        b_terms_next = b_terms_reg;
        a_lrow_next  = a_lrow_reg;
        a_lcol_next  = a_lcol_reg;
        b_lrow_next  = b_lrow_reg;
        b_lcol_next  = b_lcol_reg;
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        base_next    = base_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        acc_next     = acc_reg;
        prod_next    = prod_reg;
        pend_next    = pend_reg;
        fin_next     = fin_reg;
        emit_next    = emit_reg;
        m_valid_next = m_valid_reg && !m_tready;
        o_sts_next   = o_sts_reg;
        o_row_next   = o_row_reg;
        o_col_next   = o_col_reg;
        o_val_next   = o_val_reg;
        o_cnt_next   = o_cnt_reg;

        if (cfg_wr_en) begin
            unique case (cfg_addr)
                smm_pkg::CFG_A_ROWS: begin
                    a_rows_next = smm_pkg::clamp_dim(cfg_wdata);
                    restart     = 1'b1;
                end
                smm_pkg::CFG_INNER: begin
                    inner_next = smm_pkg::clamp_dim(cfg_wdata);
                    restart    = 1'b1;
                end
                smm_pkg::CFG_B_COLS: begin
                    b_cols_next = smm_pkg::clamp_dim(cfg_wdata);
                    restart     = 1'b1;
                end
                default: begin
                end
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    o_row_next = '0;
                    o_col_next = '0;
                    o_val_next = '0;
                    o_cnt_next = '0;
                    unique case (in_kind) inside
                        smm_pkg::KIND_LOAD_A, smm_pkg::KIND_LOAD_B: begin
                            m_valid_next = 1'b1;
                            o_sts_next   = load_sts;
                            if (load_sts == smm_pkg::STS_OK) begin
                                restart = 1'b1;
                                if (load_b) begin
                                    b_terms_next = b_terms_reg + 1'b1;
                                    b_lrow_next  = in_row;
                                    b_lcol_next  = in_col;
                                end else begin
                                    a_terms_next = a_terms_reg + 1'b1;
                                    a_lrow_next  = in_row;
                                    a_lcol_next  = in_col;
                                end
                            end
                        end
                        smm_pkg::KIND_CLEAR: begin
                            m_valid_next = 1'b1;
                            o_sts_next   = smm_pkg::STS_OK;
                            a_terms_next = '0;
                            b_terms_next = '0;
                            restart      = 1'b1;
                        end
                        default: begin
                            state_next = S_POS;
                        end
                    endcase
                end
            end
            S_POS: begin
                if (fin_reg || cur_row_reg >= a_rows_reg) begin
                    // positions used up: report the total
                    if (out_free) begin
                        fin_next     = 1'b1;
                        m_valid_next = 1'b1;
                        o_sts_next   = smm_pkg::STS_DONE;
                        o_row_next   = '0;
                        o_col_next   = '0;
                        o_val_next   = '0;
                        o_cnt_next   = emit_reg;
                        state_next   = S_IDLE;
                    end
                end else begin
                    i_next     = base_reg;
                    j_next     = '0;
                    acc_next   = '0;
                    pend_next  = 1'b0;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                if (pend_reg) begin
                    acc_next = acc_reg + prod_reg;
                end
                pend_next = 1'b0;
                if (i_reg >= a_terms_reg || j_reg >= b_terms_reg) begin
                    state_next = S_END;
                end else begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                state_next = S_RD;
                if (a_row < cur_row_reg[DW-1:0]) begin
                    // earlier row: skip for good
                    i_next    = i_reg + 1'b1;
                    base_next = i_reg + 1'b1;
                end else if (a_row != cur_row_reg[DW-1:0]) begin
                    state_next = S_END;
                end else if (b_col != cur_col_reg[DW-1:0]) begin
                    j_next = j_reg + 1'b1;
                end else if (a_col < b_row) begin
                    i_next = i_reg + 1'b1;
                end else if (a_col > b_row) begin
                    j_next = j_reg + 1'b1;
                end else begin
                    if ({1'b0, a_col} < inner_reg) begin
                        prod_next = prod_x[SW-1:0];
                        pend_next = 1'b1;
                    end
                    i_next = i_reg + 1'b1;
                    j_next = j_reg + 1'b1;
                end
            end
            S_END: begin
                if (acc_reg != '0) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        o_sts_next   = smm_pkg::STS_ENTRY;
                        o_row_next   = cur_row_reg[DW-1:0];
                        o_col_next   = cur_col_reg[DW-1:0];
                        o_val_next   = acc_reg;
                        o_cnt_next   = emit_reg + 1'b1;
                        emit_next    = emit_reg + 1'b1;
                        acc_next     = '0;
                        cur_row_next = adv_row;
                        cur_col_next = adv_col;
                        state_next   = S_IDLE;
                    end
                end else begin
                    cur_row_next = adv_row;
                    cur_col_next = adv_col;
                    state_next   = S_POS;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (restart) begin
            cur_row_next = '0;
            cur_col_next = '0;
            acc_next     = '0;
            emit_next    = '0;
            fin_next     = 1'b0;
            base_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            a_rows_reg  <= smm_pkg::DIM_MAX;
            inner_reg   <= smm_pkg::DIM_MAX;
            b_cols_reg  <= smm_pkg::DIM_MAX;
            a_terms_reg <= '0;
            b_terms_reg <= '0;
            a_lrow_reg  <= '0;
            a_lcol_reg  <= '0;
            b_lrow_reg  <= '0;
            b_lcol_reg  <= '0;
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            base_reg    <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            acc_reg     <= '0;
            pend_reg    <= 1'b0;
            fin_reg     <= 1'b0;
            emit_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            a_rows_reg  <= a_rows_next;
            inner_reg   <= inner_next;
            b_cols_reg  <= b_cols_next;
            a_terms_reg <= a_terms_next;
            b_terms_reg <= b_terms_next;
            a_lrow_reg  <= a_lrow_next;
            a_lcol_reg  <= a_lcol_next;
            b_lrow_reg  <= b_lrow_next;
            b_lcol_reg  <= b_lcol_next;
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            base_reg    <= base_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            acc_reg     <= acc_next;
            pend_reg    <= pend_next;
            fin_reg     <= fin_next;
            emit_reg    <= emit_next;
            m_valid_reg <= m_valid_next;
        end
        // payload: no reset needed
        prod_reg  <= prod_next;
        o_sts_reg <= o_sts_next;
        o_row_reg <= o_row_next;
        o_col_reg <= o_col_next;
        o_val_reg <= o_val_next;
        o_cnt_reg <= o_cnt_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_sts_reg;
    assign m_tdata  = {7'b0, o_cnt_reg, o_val_reg, o_col_reg, o_row_reg};

    // checks
    logic [CW-1:0] a_terms_inc;
    logic          entry_out;

    assign a_terms_inc = a_terms_reg + 1'b1;
    assign entry_out   = m_valid_reg && (o_sts_reg == smm_pkg::STS_ENTRY);

    `SMM_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, a_terms_reg <= CW'(MAX_TERMS), "A overflow")
    `SMM_ASSERT_NEXT(a_load_counts, aclk, aresetn, a_we, a_terms_reg == $past(a_terms_inc), "A load lost")
    `SMM_ASSERT_NOW(entry_nonzero, aclk, aresetn, entry_out, o_val_reg != '0, "zero entry sum")

endmodule

/* verif/tb_sparse_matrix_multiply.sv */
`timescale 1ns / 1ps

module tb_sparse_matrix_multiply;

    localparam int TERM_CAP   = 64;
    localparam int IDLE_LIMIT = 5000000;

    // Register index past the end of the register list.
    localparam logic [smm_pkg::CADDR_W-1:0] CFG_UNUSED = 2'd3;

    // One input word as the generator sees it.
    typedef struct {
        logic [smm_pkg::KIND_W-1:0] kind;
        logic [5:0]                 row;
        logic [5:0]                 col;
        logic [15:0]                val;
    } term_word_t;

    // One result word, split into its fields.
    typedef struct {
        logic [smm_pkg::STATUS_W-1:0] status;
        logic [5:0]                   row;
        logic [5:0]                   col;
        logic [smm_pkg::SUM_W-1:0]    value;
        logic [smm_pkg::CNT_W-1:0]    count;
    } product_word_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_wr_en;
    logic [smm_pkg::CADDR_W-1:0]     cfg_addr;
    logic [smm_pkg::CFG_W-1:0]       cfg_wdata;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [31:0]                     s_tdata  = '0;  // term_row, term_col, term_value, pad
    logic [smm_pkg::KIND_W-1:0]      s_tuser  = '0;  // kind
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [71:0]                     m_tdata;        // row, col, value, count, pad
    logic [smm_pkg::STATUS_W-1:0]    m_tuser;        // status

    sparse_matrix_multiply i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Shadow of the block: dimensions, both term stores (index 0 is A, 1 is B),
    // the enumeration cursor and the running entry count.
    int unsigned      dim_a_rows, dim_inner, dim_b_cols;
    logic [5:0]       term_row  [2][TERM_CAP];
    logic [5:0]       term_col  [2][TERM_CAP];
    logic signed [15:0] term_val [2][TERM_CAP];
    int unsigned      term_cnt  [2];
    logic [5:0]       last_row  [2];
    logic [5:0]       last_col  [2];
    int unsigned      scan_row, scan_col;
    int unsigned      entries_out;
    bit               scan_done;

    term_word_t       pending_words[$];
    product_word_t    expected_products[$];

    int unsigned      mismatches  = 0;
    int unsigned      words_in;
    int unsigned      words_out   = 0;
    int unsigned      entry_words = 0;
    int unsigned      done_words  = 0;
    int unsigned      send_idle_pct, recv_idle_pct;
    int unsigned      stall_count = 0;

    // Restart the enumeration from the top-left product position.
    function automatic void restart_scan();
        scan_row    = 0;
        scan_col    = 0;
        entries_out = 0;
        scan_done   = 1'b0;
    endfunction

    function automatic void write_dim(logic [smm_pkg::CADDR_W-1:0] idx,
                                      logic [smm_pkg::CFG_W-1:0] raw);
        int unsigned d;
        d = int'(raw);
        if (d < 1) d = 1;
        if (d > 64) d = 64;
        if (idx == smm_pkg::CFG_A_ROWS) begin
            dim_a_rows = d;
        end else if (idx == smm_pkg::CFG_INNER) begin
            dim_inner = d;
        end else if (idx == smm_pkg::CFG_B_COLS) begin
            dim_b_cols = d;
        end else begin
            return;
        end
        restart_scan();
    endfunction

    // Apply the load checks in their fixed order: range, zero, order, full.
    function automatic logic [smm_pkg::STATUS_W-1:0] store_term(int sel, logic [5:0] r,
                                                               logic [5:0] c,
                                                               logic [15:0] v);
        int unsigned rlim, clim, n;
        rlim = (sel == 0) ? dim_a_rows : dim_inner;
        clim = (sel == 0) ? dim_inner  : dim_b_cols;
        n    = term_cnt[sel];
        if (r >= rlim || c >= clim) return smm_pkg::STS_RANGE;
        if (v == '0) return smm_pkg::STS_ZERO;
        if (n > 0 && (r < last_row[sel] || (r == last_row[sel] && c <= last_col[sel])))
            return smm_pkg::STS_ORDER;
        if (n >= TERM_CAP) return smm_pkg::STS_FULL;
        term_row[sel][n] = r;
        term_col[sel][n] = c;
        term_val[sel][n] = v;
        term_cnt[sel]    = n + 1;
        last_row[sel]    = r;
        last_col[sel]    = c;
        restart_scan();
        return smm_pkg::STS_OK;
    endfunction

    // Inner-index merge of row r of A with column c of B, wrapped to 40 bits.
    function automatic logic [smm_pkg::SUM_W-1:0] dot_at(int unsigned r, int unsigned c);
        logic [smm_pkg::SUM_W-1:0] sum;
        longint                    p;
        sum = '0;
        for (int i = 0; i < term_cnt[0]; i++) begin
            if (term_row[0][i] != r || term_col[0][i] >= dim_inner) continue;
            for (int j = 0; j < term_cnt[1]; j++) begin
                if (term_col[1][j] == c && term_row[1][j] == term_col[0][i]) begin
                    p   = longint'(term_val[0][i]) * longint'(term_val[1][j]);
                    sum = sum + p[smm_pkg::SUM_W-1:0];
                end
            end
        end
        return sum;
    endfunction

    function automatic product_word_t predict_product(term_word_t w);
        product_word_t res;
        logic [smm_pkg::SUM_W-1:0] sum;
        int unsigned er, ec;
        res = '{default: '0};
        case (w.kind)
            smm_pkg::KIND_LOAD_A: res.status = store_term(0, w.row, w.col, w.val);
            smm_pkg::KIND_LOAD_B: res.status = store_term(1, w.row, w.col, w.val);
            smm_pkg::KIND_CLEAR: begin
                term_cnt[0] = 0;
                term_cnt[1] = 0;
                restart_scan();
            end
            default: begin
                res.status = smm_pkg::STS_DONE;
                while (!scan_done) begin
                    if (scan_row >= dim_a_rows) begin
                        scan_done = 1'b1;
                        break;
                    end
                    sum = dot_at(scan_row, scan_col);
                    er  = scan_row;
                    ec  = scan_col;
                    scan_col++;
                    if (scan_col >= dim_b_cols) begin
                        scan_col = 0;
                        scan_row++;
                    end
                    if (sum != '0) begin
                        entries_out++;
                        res.status = smm_pkg::STS_ENTRY;
                        res.row    = 6'(er);
                        res.col    = 6'(ec);
                        res.value  = sum;
                        break;
                    end
                end
                res.count = 13'(entries_out);
            end
        endcase
        return res;
    endfunction

    function automatic void push_word(logic [smm_pkg::KIND_W-1:0] k, int r, int c, int v);
        term_word_t w;
        w.kind = k;
        w.row  = 6'(r);
        w.col  = 6'(c);
        w.val  = 16'(v);
        pending_words.push_back(w);
    endfunction

    // Either load kind, picked at random.
    function automatic logic [smm_pkg::KIND_W-1:0] any_load();
        return ($urandom_range(0, 1) == 0) ? smm_pkg::KIND_LOAD_A : smm_pkg::KIND_LOAD_B;
    endfunction

    function automatic int nonzero_value();
        int v;
        case ($urandom_range(0, 9))
            0: v = 32767;
            1: v = -32768;
            2: v = -1;
            default: begin
                v = $urandom_range(1, 65535);
            end
        endcase
        return v;
    endfunction

    // Write one register; the write is seen at the following edge.
    task automatic cfg_write(logic [smm_pkg::CADDR_W-1:0] idx, logic [smm_pkg::CFG_W-1:0] raw);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= raw;
        write_dim(idx, raw);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Hold until every queued word has gone in and every result has come back.
    task automatic drain();
        while (pending_words.size() != 0 || s_tvalid || expected_products.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Set the dimensions and clear, then well-formed loads of A then B with random content, some noise, then fetches.
    task automatic random_phase(int unsigned ar, int unsigned in, int unsigned bc);
        int unsigned dens, nfetch;
        cfg_write(smm_pkg::CFG_A_ROWS,
                  ($urandom_range(0, 9) == 0 && ar == 1) ? 7'd0 : ar[6:0]);
        cfg_write(smm_pkg::CFG_INNER,
                  ($urandom_range(0, 9) == 0 && in == 64) ? 7'd127 : in[6:0]);
        cfg_write(smm_pkg::CFG_B_COLS, bc[6:0]);
        if ($urandom_range(0, 5) == 0) cfg_write(CFG_UNUSED, 7'($urandom_range(0, 127)));
        push_word(smm_pkg::KIND_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 65535));
        for (int m = 0; m < 2; m++) begin
            int unsigned rl, cl;
            rl   = (m == 0) ? ar : in;
            cl   = (m == 0) ? in : bc;
            dens = (rl * cl > 128) ? 8 : ($urandom_range(0, 3) == 0 ? 90 : 45);
            for (int r = 0; r < rl; r++) begin
                for (int c = 0; c < cl; c++) begin
                    if ($urandom_range(0, 99) < dens)
                        push_word(m == 0 ? smm_pkg::KIND_LOAD_A : smm_pkg::KIND_LOAD_B,
                                  r, c, nonzero_value());
                    if ($urandom_range(0, 99) < 3)
                        push_word(any_load(), $urandom_range(0, 63),
                                  $urandom_range(0, 63),
                                  $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 65535));
                end
            end
        end
        nfetch = $urandom_range(1, ar * bc / 2 + 4);
        if (nfetch > 30) nfetch = 30;
        for (int f = 0; f < nfetch; f++) begin
            push_word(smm_pkg::KIND_FETCH, $urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom_range(0, 65535));
            // An occasional load in mid-walk restarts the enumeration if it is accepted.
            if ($urandom_range(0, 19) == 0)
                push_word(any_load(), $urandom_range(0, 7), $urandom_range(0, 7),
                          nonzero_value());
        end
        words_in += pending_words.size();
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Driver: offer queued words, hold a word until it is taken.
    always @(posedge aclk) begin
        term_word_t    w;
        product_word_t res;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                w.kind = s_tuser;
                w.row  = s_tdata[5:0];
                w.col  = s_tdata[11:6];
                w.val  = s_tdata[27:12];
                res = predict_product(w);
                expected_products.push_back(res);
            end
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    w = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0, w.val, w.col, w.row};
                    s_tuser  <= w.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random, compare each result with the oldest prediction.
    always @(posedge aclk) begin
        product_word_t got, want;
        if (aresetn) begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (m_tvalid && m_tready) begin
                got.status = m_tuser;
                got.row    = m_tdata[5:0];
                got.col    = m_tdata[11:6];
                got.value  = m_tdata[51:12];
                got.count  = m_tdata[64:52];
                words_out++;
                if (expected_products.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: status %0d row %0d col %0d",
                                 got.status, got.row, got.col);
                end else begin
                    want = expected_products.pop_front();
                    if (want.status == smm_pkg::STS_ENTRY) entry_words++;
                    if (want.status == smm_pkg::STS_DONE) done_words++;
                    if (got.status !== want.status || got.row !== want.row ||
                        got.col !== want.col || got.value !== want.value ||
                        got.count !== want.count) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch at word %0d: want st %0d (%0d,%0d) val %0d ",
                                      "cnt %0d, got st %0d (%0d,%0d) val %0d cnt %0d"},
                                     words_out, want.status, want.row, want.col,
                                     $signed(want.value), want.count, got.status, got.row,
                                     got.col, $signed(got.value), got.count);
                    end
                end
            end
        end
    end

    // Watchdog: end the run if no word moves on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
            if (stall_count >= IDLE_LIMIT) begin
                $display("tb_sparse_matrix_multiply: errors");
                $finish;
            end
        end
    end

    initial begin
        int unsigned phase;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        words_in      = 0;
        send_idle_pct = 10;
        recv_idle_pct = 77;
        dim_a_rows    = 64;
        dim_inner     = 64;
        dim_b_cols    = 64;
        term_cnt[0]   = 0;
        term_cnt[1]   = 0;
        last_row      = '{default: '0};
        last_col      = '{default: '0};
        restart_scan();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extreme indices and values, zero and order rejections, done twice.
        push_word(smm_pkg::KIND_LOAD_A, 0, 0, -32768);
        push_word(smm_pkg::KIND_LOAD_A, 0, 0, 5);
        push_word(smm_pkg::KIND_LOAD_A, 63, 63, 0);
        push_word(smm_pkg::KIND_LOAD_A, 63, 63, 32767);
        push_word(smm_pkg::KIND_LOAD_B, 0, 0, -32768);
        push_word(smm_pkg::KIND_LOAD_B, 63, 63, -1);
        push_word(smm_pkg::KIND_LOAD_B, 63, 62, 1);
        repeat (4) push_word(smm_pkg::KIND_FETCH, 63, 63, 16'hFFFF);
        push_word(smm_pkg::KIND_CLEAR, 0, 0, 0);
        push_word(smm_pkg::KIND_FETCH, 0, 0, 0);
        words_in += pending_words.size();
        drain();

        // Clamping, an unused register index, and out-of-range loads.
        cfg_write(smm_pkg::CFG_A_ROWS, 7'd0);
        cfg_write(smm_pkg::CFG_INNER, 7'd127);
        cfg_write(smm_pkg::CFG_B_COLS, 7'd2);
        cfg_write(CFG_UNUSED, 7'd5);
        push_word(smm_pkg::KIND_LOAD_A, 1, 0, 1);
        push_word(smm_pkg::KIND_LOAD_B, 0, 2, 1);
        push_word(smm_pkg::KIND_LOAD_A, 0, 5, 3);
        push_word(smm_pkg::KIND_LOAD_B, 5, 1, -7);
        push_word(smm_pkg::KIND_FETCH, 0, 0, 0);
        push_word(smm_pkg::KIND_FETCH, 0, 0, 0);
        words_in += pending_words.size();
        drain();

        // Fill the A store, overflow it, then shrink the inner size over stale terms.
        cfg_write(smm_pkg::CFG_A_ROWS, 7'd9);
        cfg_write(smm_pkg::CFG_INNER, 7'd8);
        cfg_write(smm_pkg::CFG_B_COLS, 7'd1);
        push_word(smm_pkg::KIND_CLEAR, 0, 0, 0);
        for (int i = 0; i < TERM_CAP; i++)
            push_word(smm_pkg::KIND_LOAD_A, i / 8, i % 8, i + 1);
        push_word(smm_pkg::KIND_LOAD_A, 8, 0, 1);
        for (int k = 0; k < 8; k++) push_word(smm_pkg::KIND_LOAD_B, k, 0, k - 4);
        repeat (3) push_word(smm_pkg::KIND_FETCH, 0, 0, 0);
        words_in += pending_words.size();
        drain();
        cfg_write(smm_pkg::CFG_INNER, 7'd4);
        repeat (11) push_word(smm_pkg::KIND_FETCH, 0, 0, 0);
        words_in += pending_words.size();
        drain();

        // Random phases, stepping through three idling patterns as the input word count grows.
        phase = 0;
        while (words_in < 390) begin
            int unsigned ar, in, bc, pick;
            if (words_in < 180) begin
                send_idle_pct = 10;
                recv_idle_pct = 77;
            end else if (words_in < 285) begin
                send_idle_pct = 77;
                recv_idle_pct = 10;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pick = $urandom_range(0, 9);
            ar = $urandom_range(1, 6);
            in = $urandom_range(1, 6);
            bc = $urandom_range(1, 6);
            if (pick == 0) begin
                ar = 64;
                bc = $urandom_range(1, 3);
            end else if (pick == 1) begin
                in = 64;
            end else if (pick == 2) begin
                bc = 64;
                ar = $urandom_range(1, 3);
            end else if (pick == 3) begin
                ar = 1;
                in = 1;
                bc = 1;
            end
            random_phase(ar, in, bc);
            drain();
            phase++;
        end

        repeat (200) @(posedge aclk);
        $display("covered %0d input words in %0d phases, %0d results checked",
                 words_in, phase + 4, words_out);
        $display("  of which %0d product entries and %0d done reports", entry_words, done_words);
        if (mismatches == 0) begin
            $display("tb_sparse_matrix_multiply: clean");
        end else begin
            $display("tb_sparse_matrix_multiply: errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/smm_pkg.sv
sv/smm_ram.sv
sv/sparse_matrix_multiply.sv
verif/tb_sparse_matrix_multiply.sv
